FILE: design/slgu_pkg.sv
// slgu_pkg: shared types, constants and arithmetic helpers for the sigmoid layer update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slgu_pkg;
  localparam int MaxNeurons = 64;
  localparam int MaxInputs = 64;
  localparam int NW = $clog2(MaxNeurons);
  localparam int IW = $clog2(MaxInputs);

  localparam logic [2:0] KIND_WR_WEIGHT = 3'd0;
  localparam logic [2:0] KIND_WR_BIAS = 3'd1;
  localparam logic [2:0] KIND_WR_ACT = 3'd2;
  localparam logic [2:0] KIND_UPDATE = 3'd3;
  localparam logic [2:0] KIND_RD_WEIGHT = 3'd4;
  localparam logic [2:0] KIND_RD_BIAS = 3'd5;
  localparam logic [2:0] KIND_RD_DERIV = 3'd6;

  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_ACTIVE_INPUTS = 1'b1;

  // datapath operation selected by the controller
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_ERR = 4'd2;
  localparam logic [3:0] OP_G1 = 4'd3;
  localparam logic [3:0] OP_G2 = 4'd4;
  localparam logic [3:0] OP_RD = 4'd5;
  localparam logic [3:0] OP_DEL = 4'd6;
  localparam logic [3:0] OP_LRD = 4'd7;
  localparam logic [3:0] OP_WN = 4'd8;
  localparam logic [3:0] OP_ACC = 4'd9;
  localparam logic [3:0] OP_BIAS = 4'd10;
  localparam logic [3:0] OP_LRB = 4'd11;
  localparam logic [3:0] OP_BWR = 4'd12;
  localparam logic [3:0] OP_SIMPLE = 4'd13;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] neuron_index;
    logic [5:0] input_index;
    logic signed [31:0] data_value;
    logic signed [31:0] term_value;
    logic output_mode;
    logic accumulate;
  } item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [IW-1:0] j;
    logic clear_flags;
  } cmd_t;

  typedef struct packed {
    logic nok;
    logic iok;
    logic [IW:0] count;
  } status_t;

  // saturate a wide signed value to 32 bits, flag in bit 32
  function automatic logic [32:0] clip32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // round half up then shift by 16 (floor), then saturate
  function automatic logic [32:0] rnd_clip(input logic signed [63:0] p);
    logic signed [65:0] r;
    r = ($signed({{2{p[63]}}, p}) + 66'sd32768) >>> 16;
    return clip32(r);
  endfunction
endpackage
`default_nettype wire

FILE: design/slgu_ctrl.sv
// slgu_ctrl: sequencer that steps the datapath through one item
// depends on slgu_pkg
`timescale 1ns / 1ps
`default_nettype none
module slgu_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [2:0] kind,
  input wire slgu_pkg::status_t status,
  input wire logic out_free,
  output slgu_pkg::cmd_t cmd,
  output logic busy,
  output logic done
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ERR = 4'd1, S_G1 = 4'd2, S_G2 = 4'd3,
    S_RD = 4'd4, S_DEL = 4'd5, S_LRD = 4'd6, S_WN = 4'd7, S_ACC = 4'd8,
    S_BIAS = 4'd9, S_LRB = 4'd10, S_BWR = 4'd11, S_SIMPLE = 4'd12, S_DONE = 4'd13;
  logic [3:0] state, state_next;
  logic [slgu_pkg::IW:0] j, j_next;

  always_comb begin
    state_next = state;
    j_next = j;
    cmd.op = slgu_pkg::OP_NONE;
    cmd.j = j[slgu_pkg::IW-1:0];
    cmd.clear_flags = 1'b0;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = slgu_pkg::OP_LATCH;
          cmd.clear_flags = 1'b1;
          j_next = '0;
          state_next = (kind == slgu_pkg::KIND_UPDATE) ? S_ERR : S_SIMPLE;
        end
      end
      S_SIMPLE: begin cmd.op = slgu_pkg::OP_SIMPLE; state_next = S_DONE; end
      S_ERR: begin
        if (!status.nok) state_next = S_DONE;
        else begin cmd.op = slgu_pkg::OP_ERR; state_next = S_G1; end
      end
      S_G1: begin cmd.op = slgu_pkg::OP_G1; state_next = S_G2; end
      S_G2: begin
        cmd.op = slgu_pkg::OP_G2;
        state_next = (status.count == '0) ? S_BIAS : S_RD;
      end
      S_RD: begin cmd.op = slgu_pkg::OP_RD; state_next = S_DEL; end
      S_DEL: begin cmd.op = slgu_pkg::OP_DEL; state_next = S_LRD; end
      S_LRD: begin cmd.op = slgu_pkg::OP_LRD; state_next = S_WN; end
      S_WN: begin cmd.op = slgu_pkg::OP_WN; state_next = S_ACC; end
      S_ACC: begin
        cmd.op = slgu_pkg::OP_ACC;
        j_next = j + 1'b1;
        state_next = (j + 1'b1 >= status.count) ? S_BIAS : S_RD;
      end
      S_BIAS: begin cmd.op = slgu_pkg::OP_BIAS; state_next = S_LRB; end
      S_LRB: begin cmd.op = slgu_pkg::OP_LRB; state_next = S_BWR; end
      S_BWR: begin cmd.op = slgu_pkg::OP_BWR; state_next = S_DONE; end
      S_DONE: begin
        if (out_free) begin done = 1'b1; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0;
    end else begin
      state <= state_next;
      j <= j_next;
    end
  end
endmodule
`default_nettype wire

FILE: design/slgu_datapath.sv
// slgu_datapath: stores, multiplier and saturation logic for the update block
// depends on slgu_pkg
`timescale 1ns / 1ps
`default_nettype none
module slgu_datapath (
  input wire logic clk,
  input wire logic rst,
  input wire slgu_pkg::item_t item,
  input wire slgu_pkg::cmd_t cmd,
  input wire logic [15:0] learning_rate,
  input wire logic [6:0] active_inputs,
  output slgu_pkg::status_t status,
  output logic signed [31:0] read_data,
  output logic index_fault,
  output logic saturated
);
  localparam int IW = slgu_pkg::IW;
  localparam int NW = slgu_pkg::NW;
  localparam int MI = slgu_pkg::MaxInputs;

  logic signed [31:0] weight_store [slgu_pkg::MaxNeurons*MI];
  logic signed [31:0] bias_store [slgu_pkg::MaxNeurons];
  logic signed [31:0] act_store [MI];
  logic signed [31:0] acc_store [MI];
  logic [MI-1:0] acc_valid;

  slgu_pkg::item_t it;
  logic signed [31:0] e, g, p, w, x, acc, wn;
  logic sat;
  logic [IW:0] count;
  logic iok, nok;

  // live count is the smaller of the register and the store depth
  always_comb begin
    if ({25'd0, active_inputs} < MI) count = active_inputs[IW:0];
    else count = (IW + 1)'(MI);
  end
  assign iok = {1'b0, it.input_index[IW-1:0]} < count && it.input_index < MI;
  assign nok = it.neuron_index < slgu_pkg::MaxNeurons;
  assign status.nok = nok;
  assign status.iok = iok;
  assign status.count = count;

  logic [NW+IW-1:0] waddr_j, waddr_i;
  assign waddr_j = {it.neuron_index[NW-1:0], cmd.j};
  assign waddr_i = {it.neuron_index[NW-1:0], it.input_index[IW-1:0]};

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [32:0] rc, dc;
  always_comb begin
    ma = g;
    mb = x;
    case (cmd.op)
      slgu_pkg::OP_G1: begin ma = e; mb = it.data_value; end
      slgu_pkg::OP_G2: begin ma = p; mb = x; end
      slgu_pkg::OP_LRD, slgu_pkg::OP_LRB: begin
        ma = $signed({16'd0, learning_rate});
        mb = p;
      end
      slgu_pkg::OP_ACC: begin ma = g; mb = wn; end
      default: begin ma = g; mb = x; end
    endcase
    prod = ma * mb;
    rc = slgu_pkg::rnd_clip(prod);
    dc = slgu_pkg::clip32(66'(acc) + 66'(p));
  end

  always_ff @(posedge clk) begin
    if (rst) acc_valid <= '0;
    case (cmd.op)
      slgu_pkg::OP_LATCH: begin
        it <= item;
        if (cmd.clear_flags) sat <= 1'b0;
      end
      slgu_pkg::OP_ERR: begin
        logic [32:0] ec, oc;
        ec = slgu_pkg::clip32(66'(it.data_value) * 66'sd2
                              - 66'(it.term_value) * 66'sd2);
        oc = slgu_pkg::clip32(66'sd65536 - 66'(it.data_value));
        e <= it.output_mode ? $signed(ec[31:0]) : it.term_value;
        x <= $signed(oc[31:0]);
        sat <= sat | (it.output_mode & ec[32]) | oc[32];
      end
      slgu_pkg::OP_G1: begin p <= $signed(rc[31:0]); sat <= sat | rc[32]; end
      slgu_pkg::OP_G2: begin g <= $signed(rc[31:0]); sat <= sat | rc[32]; end
      slgu_pkg::OP_RD: begin
        x <= act_store[cmd.j];
        w <= weight_store[waddr_j];
        acc <= acc_valid[cmd.j] ? acc_store[cmd.j] : 32'sd0;
      end
      slgu_pkg::OP_DEL: begin p <= $signed(rc[31:0]); sat <= sat | rc[32]; end
      slgu_pkg::OP_LRD, slgu_pkg::OP_LRB: p <= $signed(rc[31:0]);
      slgu_pkg::OP_WN: begin
        logic [32:0] wc;
        wc = slgu_pkg::clip32(66'(w) - 66'(p));
        wn <= $signed(wc[31:0]);
        weight_store[waddr_j] <= $signed(wc[31:0]);
        sat <= sat | wc[32];
      end
      slgu_pkg::OP_ACC: begin
        p <= $signed(rc[31:0]);
        if (it.accumulate) sat <= sat | rc[32];
      end
      slgu_pkg::OP_BIAS: begin
        w <= bias_store[it.neuron_index[NW-1:0]];
        p <= g;
      end
      slgu_pkg::OP_BWR: begin
        logic [32:0] bc;
        bc = slgu_pkg::clip32(66'(w) - 66'(p));
        bias_store[it.neuron_index[NW-1:0]] <= $signed(bc[31:0]);
        sat <= sat | bc[32];
      end
      slgu_pkg::OP_SIMPLE: begin
        case (it.kind)
          slgu_pkg::KIND_WR_WEIGHT:
            if (iok && nok) weight_store[waddr_i] <= it.data_value;
          slgu_pkg::KIND_WR_BIAS:
            if (nok) bias_store[it.neuron_index[NW-1:0]] <= it.data_value;
          slgu_pkg::KIND_WR_ACT:
            if (iok) act_store[it.input_index[IW-1:0]] <= it.data_value;
          slgu_pkg::KIND_RD_WEIGHT: w <= weight_store[waddr_i];
          slgu_pkg::KIND_RD_BIAS: w <= bias_store[it.neuron_index[NW-1:0]];
          slgu_pkg::KIND_RD_DERIV: begin
            w <= acc_valid[it.input_index[IW-1:0]] ? acc_store[it.input_index[IW-1:0]]
                                                   : 32'sd0;
            if (iok) begin
              acc_store[it.input_index[IW-1:0]] <= 32'sd0;
              if (!rst) acc_valid[it.input_index[IW-1:0]] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // accumulator add lags its product: it is written in the cycle after, at the next read or the bias step
    if (cmd.op == slgu_pkg::OP_RD && it.kind == slgu_pkg::KIND_UPDATE && it.accumulate
        && cmd.j != '0) begin
      acc_store[cmd.j - 1'b1] <= $signed(dc[31:0]);
      if (!rst) acc_valid[cmd.j - 1'b1] <= 1'b1;
      sat <= sat | dc[32];
    end
    if (cmd.op == slgu_pkg::OP_BIAS && it.accumulate && count != '0) begin
      acc_store[count[IW-1:0] - 1'b1] <= $signed(dc[31:0]);
      if (!rst) acc_valid[count[IW-1:0] - 1'b1] <= 1'b1;
      sat <= sat | dc[32];
    end
  end

  always_comb begin
    read_data = 32'sd0;
    index_fault = 1'b0;
    saturated = 1'b0;
    case (it.kind)
      slgu_pkg::KIND_WR_WEIGHT, slgu_pkg::KIND_WR_ACT: index_fault = !iok;
      slgu_pkg::KIND_RD_WEIGHT: begin index_fault = !iok; if (iok && nok) read_data = w; end
      slgu_pkg::KIND_RD_BIAS: if (nok) read_data = w;
      slgu_pkg::KIND_RD_DERIV: begin index_fault = !iok; if (iok) read_data = w; end
      slgu_pkg::KIND_UPDATE: saturated = nok & sat;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/sigmoid_layer_gradient_update.sv
// sigmoid_layer_gradient_update: top level joining sequencer, datapath and output register
// depends on slgu_pkg, slgu_ctrl, slgu_datapath
// One item is handled at a time. An update walks N live inputs (the smaller of
// active_inputs and 64) one by one, as set by the single shared multiplier and
// the one-port weight store; each input passes the read, delta, rate, weight
// and accumulate steps. The result waits in an output register; the next item
// is taken once the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module sigmoid_layer_gradient_update (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  // [2:0] kind, [8:3] neuron_index, [14:9] input_index, [46:15] data_value,
  // [78:47] term_value, [79] output_mode, [80] accumulate, zero fill to 88
  input wire logic [87:0] s_tdata,
  output logic m_tvalid,
  input wire logic m_tready,
  // [31:0] read_data, [32] index_fault, [33] saturated, zero fill to 40
  output logic [39:0] m_tdata,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [0:0] cfg_index,
  input wire logic [31:0] cfg_data
);
  logic [15:0] learning_rate;
  logic [6:0] active_inputs;
  slgu_pkg::item_t item;
  slgu_pkg::cmd_t cmd;
  slgu_pkg::status_t status;
  logic busy, done, start;
  logic signed [31:0] rd;
  logic fault, sat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 16'd655;
      active_inputs <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index[0])
        slgu_pkg::CFG_LEARNING_RATE: learning_rate <= cfg_data[15:0];
        slgu_pkg::CFG_ACTIVE_INPUTS: active_inputs <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign item.kind = s_tdata[2:0];
  assign item.neuron_index = s_tdata[8:3];
  assign item.input_index = s_tdata[14:9];
  assign item.data_value = $signed(s_tdata[46:15]);
  assign item.term_value = $signed(s_tdata[78:47]);
  assign item.output_mode = s_tdata[79];
  assign item.accumulate = s_tdata[80];

  assign s_tready = !busy;
  assign start = s_tvalid && s_tready;

  slgu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(item.kind), .status(status),
    .out_free(!m_tvalid || m_tready), .cmd(cmd), .busy(busy), .done(done)
  );

  slgu_datapath u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .learning_rate(learning_rate),
    .active_inputs(active_inputs), .status(status), .read_data(rd),
    .index_fault(fault), .saturated(sat)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (done) m_tdata <= {6'd0, sat, fault, rd};
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("item taken while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without item");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking bench for sigmoid_layer_gradient_update, gradient step predicted in q16.16
// depends on slgu_pkg and the rtl of sigmoid_layer_gradient_update
// covers load, read, update and read-clear requests under random idling and back-pressure
`timescale 1ns / 1ps
module tb_top;
  typedef struct {
    logic [31:0] read_data;
    logic index_fault;
    logic saturated;
  } result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [87:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  sigmoid_layer_gradient_update dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] step_size;
  logic [6:0] input_count;
  int weights[slgu_pkg::MaxNeurons*slgu_pkg::MaxInputs];
  int biases[slgu_pkg::MaxNeurons];
  int activations[slgu_pkg::MaxInputs];
  int deriv_sums[slgu_pkg::MaxInputs];
  bit weight_known[slgu_pkg::MaxNeurons*slgu_pkg::MaxInputs];
  bit bias_known[slgu_pkg::MaxNeurons];
  bit act_known[slgu_pkg::MaxInputs];
  bit clipped;

  result_t pending_results[$];
  int mismatches = 0;
  bit tx_idle_en = 1;
  bit rx_idle_en = 1;
  int rx_hold = 0;
  int neuron_pool[8] = '{0, 1, 2, 3, 60, 61, 62, 63};

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int live_count();
    return (input_count < slgu_pkg::MaxInputs) ? int'(input_count) : slgu_pkg::MaxInputs;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  // round half up, floor by 2^16
  function automatic longint rnd16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic int qmul(int x, int y);
    return sat32(rnd16(longint'(x) * longint'(y)));
  endfunction

  function automatic int lr_scale(int v);
    return sat32(rnd16(longint'({48'd0, step_size}) * longint'(v)));
  endfunction

  function automatic result_t apply_gradient_item(slgu_pkg::item_t it);
    result_t r;
    int n;
    bit iok;
    int a;
    int e;
    int oma;
    int g;
    int k;
    int wn;
    n = live_count();
    iok = int'(it.input_index) < n;
    r.read_data = '0;
    r.index_fault = 0;
    r.saturated = 0;
    clipped = 0;
    k = int'(it.neuron_index) * slgu_pkg::MaxInputs + int'(it.input_index);
    if (it.kind inside {slgu_pkg::KIND_WR_WEIGHT, slgu_pkg::KIND_WR_ACT,
                        slgu_pkg::KIND_RD_WEIGHT, slgu_pkg::KIND_RD_DERIV})
      r.index_fault = !iok;
    case (it.kind)
      slgu_pkg::KIND_WR_WEIGHT: if (iok) begin
        weights[k] = it.data_value;
        weight_known[k] = 1;
      end
      slgu_pkg::KIND_WR_BIAS: begin
        biases[it.neuron_index] = it.data_value;
        bias_known[it.neuron_index] = 1;
      end
      slgu_pkg::KIND_WR_ACT: if (iok) begin
        activations[it.input_index] = it.data_value;
        act_known[it.input_index] = 1;
      end
      slgu_pkg::KIND_UPDATE: begin
        a = it.data_value;
        e = it.output_mode ? sat32(2 * (longint'(a) - longint'(it.term_value)))
                           : int'(it.term_value);
        oma = sat32(64'sd65536 - longint'(a));
        g = qmul(qmul(e, a), oma);
        for (int j = 0; j < n; j++) begin
          k = int'(it.neuron_index) * slgu_pkg::MaxInputs + j;
          wn = sat32(longint'(weights[k]) - lr_scale(qmul(g, activations[j])));
          weights[k] = wn;
          if (it.accumulate)
            deriv_sums[j] = sat32(longint'(deriv_sums[j]) + qmul(g, wn));
        end
        biases[it.neuron_index] =
          sat32(longint'(biases[it.neuron_index]) - lr_scale(g));
        r.saturated = clipped;
      end
      slgu_pkg::KIND_RD_WEIGHT: if (iok) r.read_data = weights[k];
      slgu_pkg::KIND_RD_BIAS: r.read_data = biases[it.neuron_index];
      slgu_pkg::KIND_RD_DERIV: if (iok) begin
        r.read_data = deriv_sums[it.input_index];
        deriv_sums[it.input_index] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit update_safe(int nidx);
    int n;
    n = live_count();
    if (!bias_known[nidx]) return 0;
    for (int j = 0; j < n; j++)
      if (!weight_known[nidx*slgu_pkg::MaxInputs+j] || !act_known[j]) return 0;
    return 1;
  endfunction

  function automatic slgu_pkg::item_t mk(logic [2:0] kind, int nidx, int iidx, int dv,
                                         int tv, bit om, bit acc);
    slgu_pkg::item_t it;
    it.kind = kind;
    it.neuron_index = nidx[5:0];
    it.input_index = iidx[5:0];
    it.data_value = dv;
    it.term_value = tv;
    it.output_mode = om;
    it.accumulate = acc;
    return it;
  endfunction

  // mostly small q16.16 values, now and then any 32-bit pattern
  function automatic int rand_q();
    if ($urandom_range(0, 7) == 0) return int'($urandom);
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  function automatic slgu_pkg::item_t random_item();
    slgu_pkg::item_t it;
    int nidx;
    int sel;
    sel = $urandom_range(0, 99);
    nidx = ($urandom_range(0, 1) == 0) ? neuron_pool[$urandom_range(0, 7)]
                                       : int'($urandom_range(0, 63));
    it = mk(slgu_pkg::KIND_WR_WEIGHT, nidx, $urandom_range(0, 63), rand_q(), rand_q(),
            $urandom_range(0, 1), $urandom_range(0, 1));
    if (sel < 30) begin
      it.kind = slgu_pkg::KIND_UPDATE;
      if ($urandom_range(0, 7) != 0) it.data_value = $urandom_range(0, 65536);
      if (!update_safe(nidx)) it.neuron_index = neuron_pool[$urandom_range(0, 7)];
    end else if (sel < 45) it.kind = slgu_pkg::KIND_RD_WEIGHT;
    else if (sel < 55) it.kind = slgu_pkg::KIND_RD_BIAS;
    else if (sel < 70) it.kind = slgu_pkg::KIND_RD_DERIV;
    else if (sel < 85) it.kind = slgu_pkg::KIND_WR_WEIGHT;
    else if (sel < 91) it.kind = slgu_pkg::KIND_WR_BIAS;
    else if (sel < 97) it.kind = slgu_pkg::KIND_WR_ACT;
    else it.kind = 3'd7;
    // never read a store entry that was never loaded
    if (it.kind == slgu_pkg::KIND_RD_WEIGHT && it.input_index < live_count() &&
        !weight_known[int'(it.neuron_index)*slgu_pkg::MaxInputs+int'(it.input_index)])
      it.kind = slgu_pkg::KIND_WR_WEIGHT;
    if (it.kind == slgu_pkg::KIND_RD_BIAS && !bias_known[it.neuron_index])
      it.kind = slgu_pkg::KIND_WR_BIAS;
    return it;
  endfunction

  task automatic send_item(slgu_pkg::item_t it);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, it.accumulate, it.output_mode, it.term_value, it.data_value,
                it.input_index, it.neuron_index, it.kind};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_gradient_item(it));
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == slgu_pkg::CFG_LEARNING_RATE) step_size = value[15:0];
    else input_count = value[6:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic configure(logic [15:0] lr, logic [6:0] count);
    drain_results();
    write_reg(slgu_pkg::CFG_LEARNING_RATE, {16'd0, lr});
    write_reg(slgu_pkg::CFG_ACTIVE_INPUTS, {25'd0, count});
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_load_stores();
    for (int j = 0; j < slgu_pkg::MaxInputs; j++)
      send_item(mk(slgu_pkg::KIND_WR_ACT, 0, j, $urandom_range(0, 65536), 0, 0, 0));
    for (int nidx = 0; nidx < slgu_pkg::MaxNeurons; nidx++)
      send_item(mk(slgu_pkg::KIND_WR_BIAS, nidx, 0, rand_q(), 0, 0, 0));
    foreach (neuron_pool[p])
      for (int j = 0; j < slgu_pkg::MaxInputs; j++)
        send_item(mk(slgu_pkg::KIND_WR_WEIGHT, neuron_pool[p], j, rand_q(), 0, 0, 0));
  endtask

  task automatic test_directed();
    send_item(mk(slgu_pkg::KIND_WR_WEIGHT, 63, 63, 32'h80000000, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_WEIGHT, 63, 63, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_WR_WEIGHT, 0, 0, 32'h7fffffff, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_WEIGHT, 0, 0, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_UPDATE, 1, 0, 32'h0000c000, 32'h00010000, 1, 1));
    send_item(mk(slgu_pkg::KIND_UPDATE, 2, 0, 32'h00008000, 32'hffff0000, 0, 1));
    // clipping everywhere: extreme activation and target
    send_item(mk(slgu_pkg::KIND_UPDATE, 63, 0, 32'h7fffffff, 32'h80000000, 1, 1));
    send_item(mk(slgu_pkg::KIND_UPDATE, 60, 0, 32'h80000000, 32'h7fffffff, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_BIAS, 63, 0, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_DERIV, 0, 0, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_DERIV, 0, 63, 0, 0, 0, 0));
    send_item(mk(3'd7, 63, 63, -1, -1, 1, 1));
    // index beyond the live count
    configure(16'd655, 7'd5);
    send_item(mk(slgu_pkg::KIND_WR_WEIGHT, 3, 5, 123, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_WR_ACT, 0, 63, 456, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_WEIGHT, 3, 63, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_DERIV, 0, 5, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_UPDATE, 3, 0, 32'h00004000, 32'h00020000, 1, 1));
    send_item(mk(slgu_pkg::KIND_RD_DERIV, 0, 4, 0, 0, 0, 0));
    // no live inputs: only the bias moves
    configure(16'd65535, 7'd0);
    send_item(mk(slgu_pkg::KIND_UPDATE, 0, 0, 32'h00008000, 32'h00030000, 1, 1));
    send_item(mk(slgu_pkg::KIND_RD_BIAS, 0, 0, 0, 0, 0, 0));
    send_item(mk(slgu_pkg::KIND_RD_WEIGHT, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_config_sweep();
    configure(16'd0, 7'd64);
    run_random(30);
    configure(16'd65535, 7'd1);
    run_random(30);
    configure($urandom_range(0, 65535), $urandom_range(1, 63));
    run_random(25);
    configure($urandom_range(0, 65535), 7'd127);
    run_random(25);
    configure(16'd655, 7'd0);
    run_random(10);
    configure($urandom_range(1, 4000), $urandom_range(1, 16));
    run_random(20);
  endtask

  task automatic test_backpressure();
    configure(16'd655, 7'd8);
    rx_hold = 3000;
    run_random(40);
    drain_results();
  endtask

  task automatic test_quiet_tail();
    configure(16'd655, 7'd64);
    tx_idle_en = 0;
    rx_idle_en = 0;
    run_random(90);
  endtask

  // receiver: random gaps, plus a long hold-off when asked
  initial begin
    int gap;
    gap = 0;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 0;
        rx_hold--;
      end else if (gap > 0) begin
        m_tready <= 0;
        gap--;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 0;
        gap = $urandom_range(1, 5) - 1;
      end else begin
        m_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[31:0] !== exp_r.read_data) begin
          $error("read_data expected %h actual %h", exp_r.read_data, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[32] !== exp_r.index_fault) begin
          $error("index_fault expected %b actual %b", exp_r.index_fault, m_tdata[32]);
          mismatches++;
        end
        if (m_tdata[33] !== exp_r.saturated) begin
          $error("saturated expected %b actual %b", exp_r.saturated, m_tdata[33]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    step_size = 16'd655;
    input_count = 7'd64;
    foreach (deriv_sums[j]) deriv_sums[j] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_load_stores();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_quiet_tail();
    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: files.f
design/slgu_pkg.sv
design/slgu_ctrl.sv
design/slgu_datapath.sv
design/sigmoid_layer_gradient_update.sv
dv/tb_top.sv
